[hdl/tbp_pkg.sv]
`default_nettype none

package tbp_pkg;

  // Selector carried in tuser of the input stream.
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_EDGE   = 3'd1,
    KIND_PACKET = 3'd2,
    KIND_POWER  = 3'd3,
    KIND_PEAK   = 3'd4
  } kind_t;

  // Cutout sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_CUT   = 2'd2,
    PH_BLANK = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SHORTCUT_LIMIT = 3'd0,
    REG_WINDOW_TICKS   = 3'd1,
    REG_STARTUP_TICKS  = 3'd2,
    REG_WATCHDOG_TICKS = 3'd3,
    REG_CUTOUT_DELAY   = 3'd4,
    REG_CUTOUT_LENGTH  = 3'd5,
    REG_BLANK_LENGTH   = 3'd6
  } reg_idx_t;

  localparam logic [1:0] DRIVE_OFF    = 2'd0;
  localparam logic [1:0] DRIVE_SIGNAL = 2'd1;
  localparam logic [1:0] DRIVE_CUTOUT = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED = 2'd1;
  localparam logic [1:0] STATUS_NOT_CMD = 2'd2;

  localparam logic [7:0] BYTE_IDLE = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  localparam int CFG_W = 20;

  localparam logic [15:0] RST_SHORTCUT_LIMIT = 16'd4300;
  localparam logic [15:0] RST_WINDOW_TICKS   = 16'd35000;
  localparam logic [19:0] RST_STARTUP_TICKS  = 20'd496000;
  localparam logic [15:0] RST_WATCHDOG_TICKS = 16'd32000;
  localparam logic [7:0]  RST_CUTOUT_DELAY   = 8'd14;
  localparam logic [9:0]  RST_CUTOUT_LENGTH  = 10'd216;
  localparam logic [7:0]  RST_BLANK_LENGTH   = 8'd58;

endpackage

`default_nettype wire

[hdl/track_booster_protection.sv]
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in_      slave      in_tvalid / in_tready     tdata: first_byte, power_request; tuser: kind
// out_     master     out_tvalid / out_tready   tdata: drive_mode .. peak_count
// cfg_     write      cfg_wen                   cfg_addr, cfg_wdata
//
// Every input word produces exactly one result word, in the cycle after it is
// accepted. A new word is taken in every cycle while the output register is
// empty or being emptied, so the sustained rate is one word per clock; the
// only limit is the single result register. rst_n is synchronous and active
// low: it clears all protection state, loads the default timings and empties
// the output register. A stalled result holds the input off until taken.
module track_booster_protection
  import tbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [7:0] first_byte, [8] power_request, [15:9] zero
  input  wire logic [15:0]       in_tdata,
  // [2:0] kind
  input  wire logic [2:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [1:0] drive_mode, [2] flag_on, [3] flag_emergency, [4] flag_overcurrent,
  // [5] short_led, [6] cutout_test, [8:7] cmd_status, [25:9] peak_count,
  // [31:26] zero
  output logic [31:0]            out_tdata,
  input  wire logic              cfg_wen,
  input  wire logic [2:0]        cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [15:0] limit_r, window_r, watchdog_r;
  logic [19:0] startup_r;
  logic [7:0]  delay_r, blank_r;
  logic [9:0]  cutlen_r;

  // Protection state and its next value.
  logic        on_r, on_nxt;
  logic        emerg_r, emerg_nxt;
  logic        oc_r, oc_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [16:0] peak_r, peak_nxt;
  logic [15:0] wt_r, wt_nxt;
  logic [19:0] st_r, st_nxt;
  logic        sd_r, sd_nxt;
  logic [15:0] wd_r, wd_nxt;
  phase_t      ph_r, ph_nxt;
  logic [9:0]  pt_r, pt_nxt;
  logic        sens_r, sens_nxt;
  logic        led_r, led_nxt;
  logic        tp_r, tp_nxt;

  logic [1:0]  status_nxt;
  logic [16:0] peak_out_nxt;
  logic [31:0] res_nxt;
  logic [31:0] out_tdata_r;
  logic        out_tvalid_r;

  logic        in_fire;
  logic [7:0]  first_byte;
  logic        power_request;
  kind_t       kind;

  assign first_byte    = in_tdata[7:0];
  assign power_request = in_tdata[8];
  assign kind          = kind_t'(in_tuser);

  // The output register parts the two sides: a word is taken whenever the
  // result slot is free or being drained in the same cycle.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= RST_SHORTCUT_LIMIT;
      window_r   <= RST_WINDOW_TICKS;
      startup_r  <= RST_STARTUP_TICKS;
      watchdog_r <= RST_WATCHDOG_TICKS;
      delay_r    <= RST_CUTOUT_DELAY;
      cutlen_r   <= RST_CUTOUT_LENGTH;
      blank_r    <= RST_BLANK_LENGTH;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_SHORTCUT_LIMIT: limit_r    <= cfg_wdata[15:0];
        REG_WINDOW_TICKS:   window_r   <= cfg_wdata[15:0];
        REG_STARTUP_TICKS:  startup_r  <= cfg_wdata[19:0];
        REG_WATCHDOG_TICKS: watchdog_r <= cfg_wdata[15:0];
        REG_CUTOUT_DELAY:   delay_r    <= cfg_wdata[7:0];
        REG_CUTOUT_LENGTH:  cutlen_r   <= cfg_wdata[9:0];
        REG_BLANK_LENGTH:   blank_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // All of the item's work is one pass through the block below. Steps of a
  // tick run in order; a step that powers the track off ends the tick.
  always_comb begin
    logic ended;
    logic trip;
    ended        = 1'b0;
    trip         = 1'b0;
    on_nxt       = on_r;
    emerg_nxt    = emerg_r;
    oc_nxt       = oc_r;
    cnt_nxt      = cnt_r;
    peak_nxt     = peak_r;
    wt_nxt       = wt_r;
    st_nxt       = st_r;
    sd_nxt       = sd_r;
    wd_nxt       = wd_r;
    ph_nxt       = ph_r;
    pt_nxt       = pt_r;
    sens_nxt     = sens_r;
    led_nxt      = led_r;
    tp_nxt       = tp_r;
    status_nxt   = STATUS_NOT_CMD;
    peak_out_nxt = '0;

    case (kind)
      KIND_TICK: begin
        // Packet watchdog.
        if (on_nxt) begin
          if (wd_nxt != 16'hFFFF) wd_nxt = wd_nxt + 16'd1;
          if (wd_nxt >= watchdog_r) begin
            sens_nxt  = 1'b0;
            cnt_nxt   = '0;
            wt_nxt    = '0;
            ph_nxt    = PH_IDLE;
            pt_nxt    = '0;
            tp_nxt    = 1'b0;
            st_nxt    = '0;
            sd_nxt    = 1'b0;
            emerg_nxt = 1'b1;
            on_nxt    = 1'b0;
            ended     = 1'b1;
          end
        end
        // Startup hold-off for shortcut sensing.
        if (!ended && on_nxt && !oc_nxt && !sd_nxt) begin
          if (st_nxt != 20'hFFFFF) st_nxt = st_nxt + 20'd1;
          if (st_nxt >= startup_r) begin
            sd_nxt = 1'b1;
            st_nxt = '0;
            if (ph_nxt != PH_CUT && ph_nxt != PH_BLANK) sens_nxt = 1'b1;
          end
        end
        // Shortcut counting window.
        if (!ended && on_nxt && !oc_nxt) begin
          if (wt_nxt != 16'hFFFF) wt_nxt = wt_nxt + 16'd1;
          if (wt_nxt >= window_r) begin
            trip    = cnt_nxt >= {1'b0, limit_r};
            wt_nxt  = '0;
            cnt_nxt = '0;
            if (trip) begin
              sens_nxt = 1'b0;
              ph_nxt   = PH_IDLE;
              pt_nxt   = '0;
              tp_nxt   = 1'b0;
              st_nxt   = '0;
              sd_nxt   = 1'b0;
              oc_nxt   = 1'b1;
              led_nxt  = 1'b1;
              ended    = 1'b1;
            end else begin
              led_nxt = 1'b0;
            end
          end
        end
        // Cutout sequencer.
        if (!ended && ph_nxt != PH_IDLE) begin
          if (pt_nxt != 10'h3FF) pt_nxt = pt_nxt + 10'd1;
          unique case (ph_nxt)
            PH_DELAY: begin
              if (pt_nxt >= {2'b00, delay_r}) begin
                ph_nxt   = PH_CUT;
                pt_nxt   = '0;
                sens_nxt = 1'b0;
              end
            end
            PH_CUT: begin
              if (pt_nxt >= cutlen_r) begin
                ph_nxt = PH_BLANK;
                pt_nxt = '0;
                tp_nxt = 1'b0;
              end
            end
            PH_BLANK: begin
              if (pt_nxt >= {2'b00, blank_r}) begin
                ph_nxt = PH_IDLE;
                pt_nxt = '0;
                if (sd_nxt && on_nxt && !oc_nxt) sens_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_EDGE: begin
        if (sens_r && on_r && !oc_r) begin
          led_nxt = 1'b1;
          if (cnt_r <= {1'b0, limit_r}) cnt_nxt = cnt_r + 17'd1;
          if (cnt_nxt > peak_r) peak_nxt = cnt_nxt;
        end
      end
      KIND_PACKET: begin
        if (on_r && !oc_r) begin
          wd_nxt = '0;
          if (first_byte != BYTE_IDLE && first_byte != BYTE_ONES) begin
            ph_nxt = PH_DELAY;
            pt_nxt = '0;
            tp_nxt = 1'b1;
          end
        end
      end
      KIND_POWER: begin
        if (power_request) begin
          if (emerg_r) begin
            status_nxt = STATUS_REFUSED;
          end else begin
            if (!on_r) begin
              // Fresh power-on: all state but the peak count restarts, a past trip is forgotten.
              oc_nxt   = 1'b0;
              led_nxt  = 1'b0;
              cnt_nxt  = '0;
              wt_nxt   = '0;
              sens_nxt = 1'b0;
              st_nxt   = '0;
              sd_nxt   = 1'b0;
              wd_nxt   = '0;
              ph_nxt   = PH_IDLE;
              pt_nxt   = '0;
              tp_nxt   = 1'b0;
            end
            on_nxt     = 1'b1;
            status_nxt = STATUS_OK;
          end
        end else begin
          // Power off keeps the overcurrent flag until the next power-on.
          sens_nxt   = 1'b0;
          cnt_nxt    = '0;
          wt_nxt     = '0;
          ph_nxt     = PH_IDLE;
          pt_nxt     = '0;
          tp_nxt     = 1'b0;
          st_nxt     = '0;
          sd_nxt     = 1'b0;
          on_nxt     = 1'b0;
          emerg_nxt  = 1'b0;
          status_nxt = STATUS_OK;
        end
      end
      KIND_PEAK: begin
        peak_out_nxt = peak_r;
        peak_nxt     = '0;
      end
      default: ;
    endcase
  end

  // Result word, formed from the state the item leaves behind.
  always_comb begin
    logic [1:0] drive;
    if (!on_nxt || oc_nxt) begin
      drive = DRIVE_OFF;
    end else if (ph_nxt == PH_CUT) begin
      drive = DRIVE_CUTOUT;
    end else begin
      drive = DRIVE_SIGNAL;
    end
    res_nxt = {6'd0, peak_out_nxt, status_nxt, tp_nxt, led_nxt, oc_nxt,
               emerg_nxt, on_nxt, drive};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      emerg_r <= 1'b0;
      oc_r    <= 1'b0;
      cnt_r   <= '0;
      peak_r  <= '0;
      wt_r    <= '0;
      st_r    <= '0;
      sd_r    <= 1'b0;
      wd_r    <= '0;
      ph_r    <= PH_IDLE;
      pt_r    <= '0;
      sens_r  <= 1'b0;
      led_r   <= 1'b0;
      tp_r    <= 1'b0;
    end else if (in_fire) begin
      on_r    <= on_nxt;
      emerg_r <= emerg_nxt;
      oc_r    <= oc_nxt;
      cnt_r   <= cnt_nxt;
      peak_r  <= peak_nxt;
      wt_r    <= wt_nxt;
      st_r    <= st_nxt;
      sd_r    <= sd_nxt;
      wd_r    <= wd_nxt;
      ph_r    <= ph_nxt;
      pt_r    <= pt_nxt;
      sens_r  <= sens_nxt;
      led_r   <= led_nxt;
      tp_r    <= tp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= res_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
